[src/dmrhb_pkg.sv]
package dmrhb_pkg;

    // item kinds carried in tuser
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_SET_MAG   = 3'd1;
    localparam logic [2:0] KIND_FORWARD   = 3'd2;
    localparam logic [2:0] KIND_BACKWARD  = 3'd3;
    localparam logic [2:0] KIND_SPIN_LEFT = 3'd4;
    localparam logic [2:0] KIND_SPIN_RIGHT = 3'd5;
    localparam logic [2:0] KIND_STOP      = 3'd6;

    // configuration register indexes
    localparam logic REG_RAMP_STEP     = 1'b0;
    localparam logic REG_RAMP_INTERVAL = 1'b1;

    localparam logic [7:0] RAMP_STEP_RESET     = 8'd5;
    localparam logic [7:0] RAMP_INTERVAL_RESET = 8'd20;

    // per-side target operation
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SET,
        OP_POS,
        OP_NEG,
        OP_ZERO
    } t_op;

    typedef struct packed {
        logic       fwd;
        logic       rev;
        logic [7:0] duty;
    } t_drive;

endpackage

[src/dmrhb_timer.sv]
module dmrhb_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,
    input  logic [7:0] i_interval,
    output logic       o_ramp
);
    logic [7:0] r_elapsed;
    logic [7:0] n_elapsed;
    logic [7:0] w_inc;

    always_comb begin
        // count saturates instead of wrapping
        w_inc     = (r_elapsed == 8'hff) ? r_elapsed : r_elapsed + 8'd1;
        o_ramp    = i_tick && (w_inc >= i_interval);
        n_elapsed = r_elapsed;
        if (i_tick) begin
            n_elapsed = o_ramp ? 8'd0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= 8'd0;
        end else begin
            r_elapsed <= n_elapsed;
        end
    end

endmodule

[src/dmrhb_chan.sv]
module dmrhb_chan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  dmrhb_pkg::t_op     i_op,
    input  logic [7:0]         i_mag,
    input  logic               i_ramp,
    input  logic [7:0]         i_step,
    output dmrhb_pkg::t_drive  o_drive
);
    import dmrhb_pkg::*;

    logic signed [8:0]  r_tgt;
    logic signed [8:0]  r_cur;
    logic signed [8:0]  n_tgt;
    logic signed [8:0]  n_cur;
    logic signed [8:0]  w_ramped;
    logic [7:0]         w_tgt_mag;
    logic [7:0]         w_cur_mag;
    logic signed [10:0] w_cur;
    logic signed [10:0] w_tgt;
    logic signed [10:0] w_up;
    logic signed [10:0] w_dn;

    always_comb begin
        w_tgt_mag = r_tgt[8] ? 8'(-r_tgt) : r_tgt[7:0];
        case (i_op)
            OP_SET:  n_tgt = r_tgt[8] ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
            OP_POS:  n_tgt = $signed({1'b0, w_tgt_mag});
            OP_NEG:  n_tgt = -$signed({1'b0, w_tgt_mag});
            OP_ZERO: n_tgt = 9'sd0;
            default: n_tgt = r_tgt;
        endcase
    end

    always_comb begin
        w_cur = {{2{r_cur[8]}}, r_cur};
        w_tgt = {{2{r_tgt[8]}}, r_tgt};
        w_up  = w_cur + $signed({3'b000, i_step});
        w_dn  = w_cur - $signed({3'b000, i_step});
        // step toward target, clamped so it never passes it
        if (w_cur < w_tgt) begin
            w_ramped = (w_up > w_tgt) ? r_tgt : w_up[8:0];
        end else if (w_cur > w_tgt) begin
            w_ramped = (w_dn < w_tgt) ? r_tgt : w_dn[8:0];
        end else begin
            w_ramped = r_cur;
        end
        n_cur = i_ramp ? w_ramped : r_cur;

        w_cur_mag     = n_cur[8] ? 8'(-n_cur) : n_cur[7:0];
        o_drive.fwd   = !n_cur[8] && (n_cur != 9'sd0);
        o_drive.rev   = n_cur[8];
        o_drive.duty  = w_cur_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt <= 9'sd0;
            r_cur <= 9'sd0;
        end else if (i_en) begin
            r_tgt <= n_tgt;
            r_cur <= n_cur;
        end
    end

endmodule

[src/dual_motor_ramp_hbridge_drive.sv]
// Two-side speed ramp with H-bridge direction pins and PWM duty. Every input
// transfer (tick, set magnitudes, forward, backward, spin left, spin right,
// stop) yields exactly one output transfer carrying both sides' pins and duty
// as they stand after the item. A tick advances the millisecond count; when it
// reaches ramp_interval each side's speed moves toward its target by at most
// ramp_step. The block takes one item per clock while the output is not
// stalled: an input register feeds combinational update logic whose result
// lands in the output register, so an item's result passes the input register
// and then the output register before it is offered at the output, and a
// stalled output only holds the input side once both registers are full.
module dual_motor_ramp_hbridge_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // left_magnitude, right_magnitude
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // left_fwd_pin, left_rev_pin, left_duty, right_fwd_pin, right_rev_pin,
    // right_duty, zero fill
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import dmrhb_pkg::*;

    logic [7:0] r_step;
    logic [7:0] r_interval;

    logic       r_in_valid;
    logic [2:0] r_kind;
    logic [7:0] r_lmag;
    logic [7:0] r_rmag;

    logic        r_out_valid;
    logic [19:0] r_out_data;

    logic   w_out_free;
    logic   w_en;
    logic   w_tick;
    logic   w_ramp;
    t_op    w_lop;
    t_op    w_rop;
    t_drive w_ldrv;
    t_drive w_rdrv;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_en          = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_tick        = w_en && (r_kind == KIND_TICK);

    always_comb begin
        w_lop = OP_HOLD;
        w_rop = OP_HOLD;
        case (r_kind)
            KIND_SET_MAG: begin
                w_lop = OP_SET;
                w_rop = OP_SET;
            end
            KIND_FORWARD: begin
                w_lop = OP_POS;
                w_rop = OP_POS;
            end
            KIND_BACKWARD: begin
                w_lop = OP_NEG;
                w_rop = OP_NEG;
            end
            KIND_SPIN_LEFT: begin
                w_lop = OP_NEG;
                w_rop = OP_POS;
            end
            KIND_SPIN_RIGHT: begin
                w_lop = OP_POS;
                w_rop = OP_NEG;
            end
            KIND_STOP: begin
                w_lop = OP_ZERO;
                w_rop = OP_ZERO;
            end
            default: begin
                w_lop = OP_HOLD;
                w_rop = OP_HOLD;
            end
        endcase
    end

    dmrhb_timer u_timer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_interval (r_interval),
        .o_ramp     (w_ramp)
    );

    dmrhb_chan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_op    (w_lop),
        .i_mag   (r_lmag),
        .i_ramp  (w_ramp),
        .i_step  (r_step),
        .o_drive (w_ldrv)
    );

    dmrhb_chan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_op    (w_rop),
        .i_mag   (r_rmag),
        .i_ramp  (w_ramp),
        .i_step  (r_step),
        .o_drive (w_rdrv)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= RAMP_STEP_RESET;
            r_interval <= RAMP_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_RAMP_STEP) begin
                r_step <= i_cfg_data;
            end
            if (i_cfg_idx == REG_RAMP_INTERVAL) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_kind <= s_axis_tuser;
            r_lmag <= s_axis_tdata[7:0];
            r_rmag <= s_axis_tdata[15:8];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {w_rdrv.duty, w_rdrv.rev, w_rdrv.fwd,
                           w_ldrv.duty, w_ldrv.rev, w_ldrv.fwd};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_data};

endmodule
